>>> rtl/core/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants of the k-sorted stream sorter
// Widths, the window depth and the beat and cell types used by the sorter.
// ----------------------------------------------------------------------------
package kss_pkg;

   localparam int MAX_DISTANCE = 15;
   localparam int WINDOW_DEPTH = MAX_DISTANCE + 1;
   localparam int VALUE_W      = 32;
   localparam int DIST_W       = 4;
   localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

   localparam logic [DIST_W-1:0] DISTANCE_RESET = DIST_W'(2);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } kss_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_stream;
   } kss_rsp_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } kss_slot_type;

   typedef struct packed {
      logic push;
      logic pop;
   } kss_op_type;

endpackage

>>> rtl/core/kss_cell.sv
// ----------------------------------------------------------------------------
// kss_cell: one position of the sorted window
// Holds one pending value and takes its next content from itself, its
// neighbors or the arriving value, so the row stays sorted in ascending order.
// ----------------------------------------------------------------------------
module kss_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  kss_pkg::kss_op_type                op,
   input  logic signed [kss_pkg::VALUE_W-1:0] din,
   input  kss_pkg::kss_slot_type              left_slot,
   input  logic                               left_goes,
   input  kss_pkg::kss_slot_type              right_slot,
   input  logic                               right_goes,
   output kss_pkg::kss_slot_type              slot,
   output logic                               goes
);
   import kss_pkg::*;

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // The arriving value belongs in front of this cell's value.
   assign goes = !valid_ff || (din < value_ff);

   assign slot.valid = valid_ff;
   assign slot.value = value_ff;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case ({op.push, op.pop})
         2'b10: begin
            valid_in = valid_ff | left_slot.valid | !left_goes;
            if (left_goes) begin
               value_in = left_slot.value;
            end else if (goes) begin
               value_in = din;
            end
         end
         2'b11: begin
            if (!goes) begin
               if (right_goes) begin
                  value_in = din;
               end else begin
                  value_in = right_slot.value;
               end
            end else if (!left_slot.valid) begin
               value_in = din;
            end
         end
         2'b01: begin
            valid_in = right_slot.valid;
            value_in = right_slot.value;
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

>>> rtl/core/k_sorted_stream_sorter.sv
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter: sorts a nearly sorted stream of signed values
// Keeps the distance+1 smallest pending values in a sorted row of cells,
// emits the minimum per beat once the window is full, and flushes on last.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock cycle while the response side
// keeps up, since each beat is inserted into the sorted row of cells as it
// is taken and the minimum always sits in the first cell. A beat marked last
// starts a flush that sends the whole window, one response beat a cycle while
// the response side keeps up, and holds off new requests until every pending
// value (up to sixteen) is sent; the last flushed beat carries end_of_stream.
module k_sorted_stream_sorter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  kss_pkg::kss_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output kss_pkg::kss_rsp_type             rsp_data,
   input  logic                             csr_we,
   input  logic [kss_pkg::DIST_W-1:0]       csr_wdata
);
   import kss_pkg::*;

   logic [DIST_W-1:0]  distance_ff;
   logic [DIST_W-1:0]  distance_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               flush_ff;
   logic               flush_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   kss_rsp_type        rsp_data_ff;
   kss_rsp_type        rsp_data_in;

   logic               slot_free;
   logic               req_fire;
   logic               window_full;
   logic               flush_pop;
   logic               last_one;
   kss_op_type         op;

   kss_slot_type             slots [WINDOW_DEPTH];
   logic                     goes  [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]  valid_vec;

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !flush_ff && slot_free;
   assign req_fire    = req_valid && req_ready;
   assign window_full = count_ff >= (COUNT_W'(distance_ff) + COUNT_W'(1));
   assign flush_pop   = flush_ff && slot_free;
   assign last_one    = count_ff == COUNT_W'(1);

   assign op.push = req_fire;
   assign op.pop  = (req_fire && window_full) || flush_pop;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      kss_slot_type left_slot;
      kss_slot_type right_slot;
      logic         left_goes;
      logic         right_goes;

      if (i == 0) begin : g_first
         assign left_slot = '{valid: 1'b0, value: '0};
         assign left_goes = 1'b0;
      end else begin : g_mid_left
         assign left_slot = slots[i-1];
         assign left_goes = goes[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign right_slot = '{valid: 1'b0, value: '0};
         assign right_goes = 1'b1;
      end else begin : g_mid_right
         assign right_slot = slots[i+1];
         assign right_goes = goes[i+1];
      end

      kss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .din        (req_data.value),
         .left_slot  (left_slot),
         .left_goes  (left_goes),
         .right_slot (right_slot),
         .right_goes (right_goes),
         .slot       (slots[i]),
         .goes       (goes[i])
      );

      assign valid_vec[i] = slots[i].valid;
   end

   always_comb begin
      distance_in = csr_we ? csr_wdata : distance_ff;

      count_in = count_ff;
      case ({op.push, op.pop})
         2'b10:   count_in = count_ff + COUNT_W'(1);
         2'b01:   count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase

      flush_in = flush_ff;
      if (req_fire && req_data.is_last) begin
         flush_in = 1'b1;
      end else if (flush_pop && last_one) begin
         flush_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (op.pop) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.sorted_value   = slots[0].value;
         rsp_data_in.end_of_stream  = flush_pop && last_one;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff  <= DISTANCE_RESET;
         count_ff     <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         distance_ff  <= distance_in;
         count_ff     <= count_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("window count differs from occupied cells");

   a_flush_not_empty: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> count_ff != '0)
      else $error("flush active with an empty window");

   a_head_ordered: assert property (@(posedge clock) disable iff (reset)
      (slots[0].valid && slots[1].valid) |-> slots[0].value <= slots[1].value)
      else $error("head of the window is not its minimum");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(WINDOW_DEPTH))
      else $error("window count exceeds depth");

   a_pop_has_value: assert property (@(posedge clock) disable iff (reset)
      op.pop |-> slots[0].valid)
      else $error("pop from an empty window");
`endif

endmodule
